// ===== rtl/core/phong_hit_shader_defines.svh =====
// Assertion macros shared by the phong hit shader RTL.
// Needs nothing; files that check their own logic include it.
`ifndef PHONG_HIT_SHADER_DEFINES_SVH
`define PHONG_HIT_SHADER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHS_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("phs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("phs assertion failed");

`endif

// ===== rtl/core/phs_pkg.sv =====
// Shared types, constants and width helpers for the phong hit shader.
// Depends on nothing; used by every module of the block.
package phs_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int SPEC_EXP_DEF  = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int COLOUR_W      = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_X      = 3'd0,
		REG_VIEW_Y      = 3'd1,
		REG_VIEW_Z      = 3'd2,
		REG_AMBIENT     = 3'd3,
		REG_DIFF_WEIGHT = 3'd4,
		REG_SPEC_WEIGHT = 3'd5
	} phs_reg_t;

	typedef struct packed {
		logic [15:0] view_x;
		logic [15:0] view_y;
		logic [15:0] view_z;
		logic [14:0] ambient;
		logic [14:0] diffuse;
		logic [14:0] specular;
	} phs_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} phs_qstat_t;

	localparam phs_cfg_t CFG_RESET = '{
		view_x:   16'h0000,
		view_y:   16'h0000,
		view_z:   16'hC000,
		ambient:  15'd1638,
		diffuse:  15'd8192,
		specular: 15'd8192
	};

	// Width of the rounded view.normal term: a 35 bit dot sum shifted right.
	function automatic int phs_d_width(input int frac);
		return 35 - frac;
	endfunction

	function automatic int phs_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== rtl/core/phs_queue.sv =====
// Small register queue between the front and back halves of the shader.
// Depends on phs_pkg and phong_hit_shader_defines.svh.
`include "phong_hit_shader_defines.svh"

module phs_queue #(
	parameter int WIDTH = 45,
	parameter int DEPTH = phs_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       push_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       pop_data,
	output phs_pkg::phs_qstat_t    stat
);
	import phs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;

	assign stat.full  = (cnt_q == NW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	`PHS_ASSERT(a_no_overflow, clk, arst_n, push, !stat.full)
	`PHS_ASSERT(a_no_underflow, clk, arst_n, pop, !stat.empty)
	`PHS_ASSERT(a_count_bound, clk, arst_n, 1'b1, cnt_q <= NW'(DEPTH))
	`PHS_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + NW'(1))

endmodule

// ===== rtl/core/phs_front.sv =====
// Front half of the shader: takes a hit beat and forms the rounded view.normal term.
// Depends on phs_pkg; feeds phs_queue.
module phs_front #(
	parameter int FRAC_BITS = phs_pkg::FRAC_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            start,
	output logic                                            busy,
	input  logic signed [15:0]                              normal_x,
	input  logic signed [15:0]                              normal_y,
	input  logic signed [15:0]                              normal_z,
	input  logic [phs_pkg::COLOUR_W-1:0]                    colour,
	input  phs_pkg::phs_cfg_t                               cfg,
	input  phs_pkg::phs_qstat_t                             qstat,
	output logic                                            push,
	output logic [phs_pkg::phs_d_width(FRAC_BITS)+phs_pkg::COLOUR_W-1:0] push_data
);
	import phs_pkg::*;

	localparam int DW = phs_d_width(FRAC_BITS);
	localparam logic signed [34:0] RND = 35'(1) <<< (FRAC_BITS - 1);

	logic signed [15:0] vx, vy, vz;
	logic signed [31:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic [COLOUR_W-1:0] colour_s1, colour_s2;
	logic               valid_s1, valid_s2;
	logic signed [DW-1:0] d_s2;
	logic signed [34:0] dot;
	logic adv_s1, adv_s2, accept;

	assign vx = cfg.view_x;
	assign vy = cfg.view_y;
	assign vz = cfg.view_z;

	// Stage 2 drains into the queue; stage 1 moves whenever stage 2 has room.
	assign adv_s2 = !valid_s2 || !qstat.full;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign busy   = !adv_s1;
	assign accept = start && adv_s1;
	assign push   = valid_s2 && !qstat.full;

	assign dot = 35'(prod_x_s1) + 35'(prod_y_s1) + 35'(prod_z_s1) + RND;

	assign push_data = {d_s2, colour_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= accept;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= 32'(normal_x) * 32'(vx);
			prod_y_s1 <= 32'(normal_y) * 32'(vy);
			prod_z_s1 <= 32'(normal_z) * 32'(vz);
			colour_s1 <= colour;
		end
		if (adv_s2 && valid_s1) begin
			// round half up, then drop the fraction bits
			d_s2      <= dot[34:FRAC_BITS];
			colour_s2 <= colour_s1;
		end
	end

endmodule

// ===== rtl/core/phs_back.sv =====
// Back half of the shader: specular power chain, diffuse and channel blend.
// Depends on phs_pkg; pops from phs_queue every cycle it holds a beat.
module phs_back #(
	parameter int FRAC_BITS     = phs_pkg::FRAC_BITS_DEF,
	parameter int SPEC_EXPONENT = phs_pkg::SPEC_EXP_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  phs_pkg::phs_qstat_t                             qstat,
	input  logic [phs_pkg::phs_d_width(FRAC_BITS)+phs_pkg::COLOUR_W-1:0] pop_data,
	input  phs_pkg::phs_cfg_t                               cfg,
	output logic                                            pop,
	output logic                                            done,
	output logic [7:0]                                      shade_red,
	output logic [7:0]                                      shade_green,
	output logic [7:0]                                      shade_blue
);
	import phs_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int ONE  = 1 << F;
	localparam int DW   = phs_d_width(F);
	localparam int QW   = DW + COLOUR_W;
	localparam int XW   = phs_max(2 * DW + 2, 2 * F + 3);
	localparam int RBW  = DW + 17 - F;
	localparam int BW   = phs_max(RBW, 16) + 1;
	localparam int CW   = phs_max(phs_max(BW + 9, 25), F + 10) + 1;
	localparam int VW   = CW - F;
	localparam int NPOW = SPEC_EXPONENT - 1;

	localparam logic [XW-1:0]          RND_X = XW'(1) << (F - 1);
	localparam logic [XW-1:0]          LO_T  = XW'(ONE + 1) << F;
	localparam logic [XW-1:0]          HI_T  = XW'(2 * ONE) << F;
	localparam logic signed [DW+16:0]  RND_B = (DW + 17)'(1) <<< (F - 1);
	localparam logic [2*F+1:0]         RND_P = (2 * F + 2)'(1) << (F - 1);
	localparam logic [F+15:0]          RND_S = (F + 16)'(1) << (F - 1);
	localparam logic signed [CW-1:0]   RND_C = CW'(1) <<< (F - 1);
	localparam logic signed [VW-1:0]   SAT   = VW'(255);

	// queue head
	logic signed [DW-1:0]   d_in;
	logic signed [2*DW-1:0] dsq;
	logic signed [DW:0]     nd;
	logic signed [15:0]     dwt;
	logic signed [DW+16:0]  dprod;

	// stage 1
	logic                   valid_s1;
	logic [2*DW-1:0]        dsq_s1;
	logic signed [DW+16:0]  dprod_s1;
	logic [COLOUR_W-1:0]    colour_s1;

	// stage 2 and the power chain behind it
	logic [XW-1:0]          x2, x2_sh;
	logic [F:0]             base;
	logic signed [DW+16:0]  rb;
	logic signed [RBW-1:0]  rbs;
	logic signed [BW-1:0]   rbs_x, amb_x;
	logic                   valid_s2  [NPOW+1];
	logic [F:0]             p_s2      [NPOW+1];
	logic [F:0]             base_s2   [NPOW+1];
	logic signed [BW-1:0]   bright_s2 [NPOW+1];
	logic [COLOUR_W-1:0]    colour_s2 [NPOW+1];

	// stage 4: specular term
	logic [F+15:0]          sprod;
	logic                   valid_s4;
	logic [14:0]            spec_s4;
	logic signed [BW-1:0]   bright_s4;
	logic [COLOUR_W-1:0]    colour_s4;

	// stage 5 and 6: channel blend and saturate
	logic [23:0]            spec255;
	logic signed [BW+8:0]   cprod [3];
	logic signed [CW-1:0]   csum  [3];
	logic signed [CW-1:0]   cr    [3];
	logic signed [VW-1:0]   cv    [3];
	logic                   valid_s5, valid_s6;
	logic signed [CW-1:0]   chan_s5  [3];
	logic [7:0]             shade_s6 [3];

	assign pop  = !qstat.empty;
	assign d_in = pop_data[QW-1:COLOUR_W];
	assign dsq  = (2 * DW)'(d_in) * (2 * DW)'(d_in);
	assign nd   = -((DW + 1)'(d_in));
	assign dwt  = {1'b0, cfg.diffuse};
	assign dprod = (DW + 17)'(nd) * (DW + 17)'(dwt);

	// Specular base: round(2*d*d) - ONE, clamped to 0..ONE by thresholds on the raw sum.
	assign x2    = (XW'(dsq_s1) << 1) + RND_X;
	assign x2_sh = x2 >> F;
	always_comb begin
		if (x2 < LO_T) begin
			base = '0;
		end else if (x2 >= HI_T) begin
			base = (F + 1)'(ONE);
		end else begin
			base = (F + 1)'(x2_sh - XW'(ONE));
		end
	end

	assign rb    = dprod_s1 + RND_B;
	assign rbs   = rb[DW+16:F];
	assign rbs_x = BW'(rbs);
	assign amb_x = BW'(cfg.ambient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k <= NPOW; k++) begin
				valid_s2[k] <= 1'b0;
			end
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1    <= pop;
			valid_s2[0] <= valid_s1;
			for (int k = 0; k < NPOW; k++) begin
				valid_s2[k+1] <= valid_s2[k];
			end
			valid_s4 <= valid_s2[NPOW];
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		dsq_s1       <= dsq;
		dprod_s1     <= dprod;
		colour_s1    <= pop_data[COLOUR_W-1:0];
		p_s2[0]      <= base;
		base_s2[0]   <= base;
		bright_s2[0] <= rbs_x + amb_x;
		colour_s2[0] <= colour_s1;
	end

	// One multiply per power step, each step registered.
	for (genvar k = 0; k < NPOW; k++) begin : g_pow
		logic [2*F+1:0] pprod;
		logic [2*F+1:0] pr;

		assign pprod = (2 * F + 2)'(p_s2[k]) * (2 * F + 2)'(base_s2[k]);
		assign pr    = (pprod + RND_P) >> F;

		always_ff @(posedge clk) begin
			p_s2[k+1]      <= pr[F:0];
			base_s2[k+1]   <= base_s2[k];
			bright_s2[k+1] <= bright_s2[k];
			colour_s2[k+1] <= colour_s2[k];
		end
	end

	assign sprod = (F + 16)'(p_s2[NPOW]) * (F + 16)'(cfg.specular);

	always_ff @(posedge clk) begin
		spec_s4   <= 15'((sprod + RND_S) >> F);
		bright_s4 <= bright_s2[NPOW];
		colour_s4 <= colour_s2[NPOW];
	end

	assign spec255 = (24'(spec_s4) << 8) - 24'(spec_s4);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			cprod[ch] = (BW + 9)'($signed({1'b0, colour_s4[ch*8 +: 8]})) *
				(BW + 9)'(bright_s4);
			csum[ch]  = CW'(cprod[ch]) + CW'($signed({1'b0, spec255}));
			cr[ch]    = chan_s5[ch] + RND_C;
			cv[ch]    = cr[ch][CW-1:F];
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			chan_s5[ch] <= csum[ch];
			// clamp both ends to the 8-bit range
			if (cv[ch] < 0) begin
				shade_s6[ch] <= 8'd0;
			end else if (cv[ch] > SAT) begin
				shade_s6[ch] <= 8'd255;
			end else begin
				shade_s6[ch] <= cv[ch][7:0];
			end
		end
	end

	assign done        = valid_s6;
	assign shade_blue  = shade_s6[0];
	assign shade_green = shade_s6[1];
	assign shade_red   = shade_s6[2];

endmodule

// ===== rtl/core/phong_hit_shader.sv =====
// Phong hit shader top level: configuration registers, front, queue and back.
// Depends on phs_pkg, phs_front, phs_queue and phs_back.
//
// Use: drive a hit (unit normal in Q1.14 plus surface colour) with start high; the
// beat is taken at the rising edge where start is high and busy is low. Each hit
// gives one shaded colour, on shade_red/green/blue for exactly one cycle with done
// high; the receiver has to take it then.
// Throughput: one hit per cycle. The back half pops the queue whenever it holds a
// beat and never stalls, so busy stays low in normal operation.
// Path: two front stages, one queue slot, then the back half: the diffuse stage, the
// multiply chain that raises the specular base to SPEC_EXPONENT, one multiply per
// stage, then the specular and blend stages; done is registered at the end.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge;
// indexes beyond the list are dropped. Write only while no hit is in flight.
// Reset: arst_n clears all pipeline valid flags and the queue and loads the
// default view direction (0, 0, -1), ambient 0.1 and both weights 0.5.
module phong_hit_shader #(
	parameter int FRAC_BITS     = phs_pkg::FRAC_BITS_DEF,
	parameter int SPEC_EXPONENT = phs_pkg::SPEC_EXP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [15:0]               normal_x,
	input  logic signed [15:0]               normal_y,
	input  logic signed [15:0]               normal_z,
	input  logic [7:0]                       surf_red,
	input  logic [7:0]                       surf_green,
	input  logic [7:0]                       surf_blue,
	input  logic                             cfg_wr_en,
	input  logic [phs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [phs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             done,
	output logic [7:0]                       shade_red,
	output logic [7:0]                       shade_green,
	output logic [7:0]                       shade_blue
);
	import phs_pkg::*;

	localparam int QW = phs_d_width(FRAC_BITS) + COLOUR_W;

	phs_cfg_t   cfg_q;
	phs_qstat_t qstat;
	logic       push, pop;
	logic [QW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (phs_reg_t'(cfg_index))
				REG_VIEW_X:      cfg_q.view_x   <= cfg_data;
				REG_VIEW_Y:      cfg_q.view_y   <= cfg_data;
				REG_VIEW_Z:      cfg_q.view_z   <= cfg_data;
				REG_AMBIENT:     cfg_q.ambient  <= cfg_data[14:0];
				REG_DIFF_WEIGHT: cfg_q.diffuse  <= cfg_data[14:0];
				REG_SPEC_WEIGHT: cfg_q.specular <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	phs_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.colour    ({surf_red, surf_green, surf_blue}),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	phs_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	phs_back #(
		.FRAC_BITS     (FRAC_BITS),
		.SPEC_EXPONENT (SPEC_EXPONENT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.cfg         (cfg_q),
		.pop         (pop),
		.done        (done),
		.shade_red   (shade_red),
		.shade_green (shade_green),
		.shade_blue  (shade_blue)
	);

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for phong_hit_shader: directed and random hits under several view
// and weight settings, each result checked against an in-bench shading predictor.
// Depends on phs_pkg and the phong_hit_shader RTL.
module testbench;
	import phs_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int SPEC_POWER = SPEC_EXP_DEF;
	localparam longint UNITY = longint'(1) << FRAC;
	localparam int LATENCY = 8 + SPEC_POWER;
	localparam int CYCLE_LIMIT = 120000;
	localparam int PRINT_LIMIT = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic signed [15:0] Q_ONE = 16'sd16384;
	localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;
	localparam logic signed [15:0] Q_DIAG = 16'sd11585;
	localparam logic [15:0] W_ONE = 16'd16384;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} hit_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [7:0] surf_red, surf_green, surf_blue;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic [7:0] shade_red, shade_green, shade_blue;

	phs_cfg_t shade_cfg;
	shade_t pending_shades[$];
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int config_writes = 0;
	int clipped_high = 0;
	int clipped_low = 0;
	int cycle_count = 0;

	phong_hit_shader dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.surf_red   (surf_red),
		.surf_green (surf_green),
		.surf_blue  (surf_blue),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.shade_red  (shade_red),
		.shade_green(shade_green),
		.shade_blue (shade_blue)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("phong_hit_shader: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// ---------------- shading predictor ----------------

	// Drop FRAC fraction bits, rounding half up.
	function automatic longint rescale(longint x);
		return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic [7:0] blend_channel(logic [7:0] colour, longint bright,
			longint spec);
		longint v;
		v = rescale(longint'(colour) * bright + 255 * spec);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic shade_t shade_hit(hit_t h);
		longint vx, vy, vz, d, base, p, bright, spec;
		shade_t s;
		vx = longint'($signed(shade_cfg.view_x));
		vy = longint'($signed(shade_cfg.view_y));
		vz = longint'($signed(shade_cfg.view_z));
		d = rescale(vx * longint'(h.nx) + vy * longint'(h.ny) + vz * longint'(h.nz));
		// Highlight base is 2*d*d - 1, clipped to 0..1 since normals need not be unit.
		base = rescale(2 * d * d) - UNITY;
		if (base < 0)
			base = 0;
		if (base > UNITY)
			base = UNITY;
		p = UNITY;
		repeat (SPEC_POWER)
			p = rescale(p * base);
		bright = longint'(shade_cfg.ambient) + rescale(-d * longint'(shade_cfg.diffuse));
		spec = rescale(p * longint'(shade_cfg.specular));
		s.red = blend_channel(h.red, bright, spec);
		s.green = blend_channel(h.green, bright, spec);
		s.blue = blend_channel(h.blue, bright, spec);
		return s;
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin : check_results
		shade_t want;
		if (arst_n && done) begin
			if (pending_shades.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
					shade_red, shade_green, shade_blue));
			end else begin
				want = pending_shades.pop_front();
				if (shade_red !== want.red)
					report_mismatch($sformatf("result %0d red %0d, want %0d",
						results_checked, shade_red, want.red));
				if (shade_green !== want.green)
					report_mismatch($sformatf("result %0d green %0d, want %0d",
						results_checked, shade_green, want.green));
				if (shade_blue !== want.blue)
					report_mismatch($sformatf("result %0d blue %0d, want %0d",
						results_checked, shade_blue, want.blue));
				results_checked++;
			end
		end
	end

	// ---------------- drivers ----------------

	task automatic send_hit(hit_t h);
		shade_t s;
		@(negedge clk);
		start <= 1'b1;
		normal_x <= h.nx;
		normal_y <= h.ny;
		normal_z <= h.nz;
		surf_red <= h.red;
		surf_green <= h.green;
		surf_blue <= h.blue;
		do
			@(posedge clk);
		while (busy);
		s = shade_hit(h);
		pending_shades.push_back(s);
		items_sent++;
		if (s.red == 8'd255 || s.green == 8'd255 || s.blue == 8'd255)
			clipped_high++;
		if (s.red == 8'd0 || s.green == 8'd0 || s.blue == 8'd0)
			clipped_low++;
	endtask

	task automatic idle_burst(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// Hold off until every pending beat has come out and the pipe is empty.
	task automatic wait_idle();
		int guard;
		guard = 0;
		idle_burst(1);
		while (pending_shades.size() != 0 && guard < 4 * LATENCY + 100) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_VIEW_X:      shade_cfg.view_x = data;
			REG_VIEW_Y:      shade_cfg.view_y = data;
			REG_VIEW_Z:      shade_cfg.view_z = data;
			REG_AMBIENT:     shade_cfg.ambient = data[14:0];
			REG_DIFF_WEIGHT: shade_cfg.diffuse = data[14:0];
			REG_SPEC_WEIGHT: shade_cfg.specular = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		config_writes++;
	endtask

	task automatic set_config(vec_t view, logic [15:0] amb, logic [15:0] dw,
			logic [15:0] sw);
		write_reg(REG_VIEW_X, view.x);
		write_reg(REG_VIEW_Y, view.y);
		write_reg(REG_VIEW_Z, view.z);
		write_reg(REG_AMBIENT, amb);
		write_reg(REG_DIFF_WEIGHT, dw);
		write_reg(REG_SPEC_WEIGHT, sw);
	endtask

	// ---------------- random generation ----------------

	function automatic real rand_real();
		return 2.0 * $itor($urandom_range(0, 1000000)) / 1000000.0 - 1.0;
	endfunction

	function automatic logic signed [15:0] to_q14(real r);
		int q;
		q = $rtoi(r * 16384.0 + ((r >= 0.0) ? 0.5 : -0.5));
		if (q > 16384)
			q = 16384;
		if (q < -16384)
			q = -16384;
		return q[15:0];
	endfunction

	function automatic vec_t normalize_vec(real x, real y, real z);
		real len;
		vec_t v;
		len = $sqrt(x * x + y * y + z * z);
		if (len < 0.001)
			return '{16'sd0, 16'sd0, Q_ONE};
		v.x = to_q14(x / len);
		v.y = to_q14(y / len);
		v.z = to_q14(z / len);
		return v;
	endfunction

	function automatic vec_t random_view();
		vec_t v;
		logic signed [15:0] axis;
		if ($urandom_range(0, 3) != 0)
			return normalize_vec(rand_real(), rand_real(), rand_real());
		axis = $urandom_range(0, 1) ? Q_ONE : Q_NEG_ONE;
		v = '0;
		case ($urandom_range(0, 2))
			0: v.x = axis;
			1: v.y = axis;
			default: v.z = axis;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return W_ONE;
			default: return 16'($urandom_range(0, 16384));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return Q_ONE;
			1: return Q_NEG_ONE;
			2: return 16'sd1;
			3: return -16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	function automatic logic [7:0] rand_colour();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly unit normals; a share aimed along the view axis reaches the highlight.
	function automatic hit_t random_hit();
		hit_t h;
		vec_t n;
		real vx, vy, vz, sgn;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 4) begin
			n = normalize_vec(rand_real(), rand_real(), rand_real());
		end else if (kind <= 7) begin
			vx = $itor($signed(shade_cfg.view_x)) / 16384.0;
			vy = $itor($signed(shade_cfg.view_y)) / 16384.0;
			vz = $itor($signed(shade_cfg.view_z)) / 16384.0;
			sgn = $urandom_range(0, 1) ? 1.0 : -1.0;
			n = normalize_vec(sgn * vx + 0.3 * rand_real(), sgn * vy + 0.3 * rand_real(),
				sgn * vz + 0.3 * rand_real());
		end else if (kind == 8) begin
			n.x = 16'(int'($urandom_range(0, 32768)) - 16384);
			n.y = 16'(int'($urandom_range(0, 32768)) - 16384);
			n.z = 16'(int'($urandom_range(0, 32768)) - 16384);
		end else begin
			n.x = pick_extreme();
			n.y = pick_extreme();
			n.z = pick_extreme();
		end
		h.nx = n.x;
		h.ny = n.y;
		h.nz = n.z;
		h.red = rand_colour();
		h.green = rand_colour();
		h.blue = rand_colour();
		return h;
	endfunction

	// ---------------- tests ----------------

	// Reset settings: camera along -z, ambient 0.1, both weights 0.5.
	task automatic test_reset_defaults();
		send_hit('{16'sd0, 16'sd0, Q_ONE, 8'd255, 8'd255, 8'd255});
		send_hit('{16'sd0, 16'sd0, Q_ONE, 8'd0, 8'd0, 8'd0});
		send_hit('{16'sd0, 16'sd0, Q_NEG_ONE, 8'd255, 8'd128, 8'd1});
		send_hit('{Q_ONE, 16'sd0, 16'sd0, 8'd200, 8'd100, 8'd50});
		send_hit('{16'sd0, Q_NEG_ONE, 16'sd0, 8'd255, 8'd255, 8'd255});
		send_hit('{16'sd0, 16'sd0, 16'sd0, 8'd255, 8'd7, 8'd170});
		send_hit('{Q_ONE, Q_ONE, Q_ONE, 8'd85, 8'd255, 8'd0});
		send_hit('{Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, 8'd255, 8'd0, 8'd255});
		send_hit('{Q_DIAG, 16'sd0, Q_DIAG, 8'd128, 8'd128, 8'd128});
		wait_idle();
	endtask

	task automatic test_config_extremes();
		// Non-unit view with full weights: drives channels to both clamp ends.
		set_config('{Q_ONE, Q_ONE, Q_ONE}, W_ONE, W_ONE, W_ONE);
		send_hit('{Q_ONE, Q_ONE, Q_ONE, 8'd255, 8'd255, 8'd255});
		send_hit('{Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, 8'd255, 8'd0, 8'd128});
		send_hit('{16'sd0, 16'sd0, 16'sd0, 8'd200, 8'd100, 8'd50});
		wait_idle();
		// No ambient, no highlight: a back-facing hit clamps to zero.
		set_config('{Q_NEG_ONE, 16'sd0, 16'sd0}, 16'd0, W_ONE, 16'd0);
		send_hit('{Q_ONE, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255});
		send_hit('{Q_NEG_ONE, 16'sd0, 16'sd0, 8'd255, 8'd17, 8'd0});
		send_hit('{16'sd0, Q_ONE, 16'sd0, 8'd90, 8'd255, 8'd3});
		wait_idle();
		// Writes past the register list must leave the settings alone.
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h5A5A);
		send_hit('{Q_NEG_ONE, 16'sd0, 16'sd0, 8'd99, 8'd200, 8'd255});
		send_hit('{Q_DIAG, 16'sd0, -Q_DIAG, 8'd255, 8'd255, 8'd255});
		wait_idle();
	endtask

	// The sender stops mid-stream until the pipe has drained, then resumes.
	task automatic test_drain_pause();
		set_config(random_view(), rand_weight(), rand_weight(), rand_weight());
		repeat (20)
			send_hit(random_hit());
		wait_idle();
		repeat (20)
			send_hit(random_hit());
		wait_idle();
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		bit with_gaps;
		for (int ph = 0; ph < phases; ph++) begin
			set_config(random_view(), rand_weight(), rand_weight(), rand_weight());
			with_gaps = (ph % 3) != 2;
			for (int i = 0; i < per_phase; i++) begin
				send_hit(random_hit());
				if (with_gaps && $urandom_range(0, 3) == 0)
					idle_burst($urandom_range(1, 14));
			end
			wait_idle();
		end
	endtask

	task automatic test_streaming(int count);
		set_config(random_view(), rand_weight(), rand_weight(), rand_weight());
		repeat (count)
			send_hit(random_hit());
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		normal_x = '0;
		normal_y = '0;
		normal_z = '0;
		surf_red = '0;
		surf_green = '0;
		surf_blue = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shade_cfg = CFG_RESET;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_config_extremes();
		test_drain_pause();
		test_random_phases(7, 110);
		test_streaming(130);

		idle_burst(1);
		guard = 0;
		while (pending_shades.size() != 0 && guard < 4 * LATENCY + 100) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4)
			@(posedge clk);
		if (pending_shades.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_shades.size()));

		$display("hits sent %0d, results checked %0d, register writes %0d",
			items_sent, results_checked, config_writes);
		$display("results with a channel clipped high %0d, clipped low %0d, errors %0d",
			clipped_high, clipped_low, errors);
		if (errors == 0)
			$display("phong_hit_shader: match");
		else
			$display("phong_hit_shader: mismatch");
		$finish;
	end

endmodule
